// ===== rtl/gfoa_pkg.sv =====
// Shared types, constants and helpers for the GF(p) orthogonal array generator.
package gfoa_pkg;

    localparam int MaxDigits   = 10;
    localparam int TableDepth  = 2048;
    localparam int MaxRows     = 4096;
    localparam int DigitW      = 3;
    localparam int VecW        = DigitW * MaxDigits;
    localparam int AddrW       = $clog2(TableDepth);
    localparam int RowW        = 12;
    localparam int ColW        = 11;
    localparam int CntW        = $clog2(MaxDigits + 1);
    localparam int RowCntW     = 13;

    localparam logic [1:0] RegBaseSelect = 2'd0;
    localparam logic [1:0] RegDigitCount = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_UNIT,
        ST_FILL_SCAN,
        ST_FILL_SPLIT,
        ST_QUERY_READ,
        ST_QUERY_SPLIT,
        ST_QUERY_DONE
    } state_t;

    // Size facts derived from the configuration
    typedef struct packed {
        logic               ok;
        logic [2:0]         prime;
        logic [RowCntW-1:0] rows;
        logic [ColW-1:0]    cols;
    } size_t_t;

    function automatic logic [2:0] prime_of(input logic [1:0] sel);
        logic [2:0] p;
        begin
            case (sel)
                2'd0:    p = 3'd2;
                2'd1:    p = 3'd3;
                2'd2:    p = 3'd5;
                default: p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== rtl/gf_prime_orthogonal_array_generator_top.sv =====
// Top level: sequencer, shared mod-p digit unit and column table.
//
//  channel  | signals                                   | dir
//  config   | wr_en, wr_index[1:0], wr_data[3:0]        | in
//  request  | start, busy, row_index, column_index      | in/out
//  result   | done, level, row_count, column_count,     | out
//           | out_of_range                              |
//
// A request passes one table read, n steps of the shared unit that peel one
// base-p digit off the row and accumulate the product, and one step to register
// the result (n digits, up to 10). The next request can be taken at the edge
// that takes the result.
// After reset or a register write, if the size is legal, the table is refilled:
// n unit columns, then a scan step plus one split step per digit for every
// candidate value below p^n; busy stays high meanwhile. The result strobe lasts
// one cycle.
module gf_prime_orthogonal_array_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [3:0]  wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] row_index,
    input  logic [10:0] column_index,
    output logic        done,
    output logic [2:0]  level,
    output logic [12:0] row_count,
    output logic [10:0] column_count,
    output logic        out_of_range
);
    import gfoa_pkg::*;

    logic [1:0]         base_reg;
    logic [3:0]         ndig_reg;
    logic               refill_reg;
    state_t             state_reg, state_next;
    size_t_t            size;
    logic [RowW-1:0]    val_reg, val_next;
    logic [RowW-1:0]    cand_reg;
    logic [CntW-1:0]    k_reg;
    logic [AddrW-1:0]   fill_reg;
    logic [VecW-1:0]    vec_reg;
    logic [3:0]         nz_reg;
    logic [2:0]         lead_reg;
    logic [2:0]         sum_reg;
    logic               oor_reg;
    logic [ColW-1:0]    col_reg;
    logic [2:0]         digit;
    logic [RowW-1:0]    quot;
    logic [2:0]         sum_next;
    logic [4:0]         prod;
    logic [2:0]         vdig;
    logic               ram_we;
    logic [AddrW-1:0]   ram_addr;
    logic [VecW-1:0]    ram_wdata;
    logic [VecW-1:0]    ram_rdata;
    logic [2:0]         level_reg;
    logic               done_reg;
    logic               oor_out_reg;

    gfoa_size u_size (
        .base_select (base_reg),
        .digit_count (ndig_reg),
        .size        (size)
    );

    gfoa_ram #(.Width(VecW), .Depth(TableDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared unit: divide by p (constant per config), take one digit and accumulate the digit product mod p
    always_comb
    begin
        case (size.prime)
            3'd2:    quot = val_reg >> 1;
            3'd3:    quot = RowW'((24'(val_reg) * 24'd2731) >> 13);
            3'd5:    quot = RowW'((24'(val_reg) * 24'd3277) >> 14);
            default: quot = '0;
        endcase
        digit    = 3'(val_reg - RowW'(quot * RowW'(size.prime)));
        val_next = quot;
        vdig     = ram_rdata[DigitW*(k_reg - CntW'(1)) +: DigitW];
        prod     = 5'(vdig * digit) + 5'(sum_reg);
        case (size.prime)
            3'd2:    sum_next = 3'(prod % 5'd2);
            3'd3:    sum_next = (prod >= 5'd15) ? 3'(prod - 5'd15) :
                                (prod >= 5'd12) ? 3'(prod - 5'd12) :
                                (prod >= 5'd9)  ? 3'(prod - 5'd9) :
                                (prod >= 5'd6)  ? 3'(prod - 5'd6) :
                                (prod >= 5'd3)  ? 3'(prod - 5'd3) : 3'(prod);
            3'd5:    sum_next = (prod >= 5'd20) ? 3'(prod - 5'd20) :
                                (prod >= 5'd15) ? 3'(prod - 5'd15) :
                                (prod >= 5'd10) ? 3'(prod - 5'd10) :
                                (prod >= 5'd5)  ? 3'(prod - 5'd5) : 3'(prod);
            default: sum_next = 3'd0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (refill_reg)
                    state_next = size.ok ? ST_FILL_UNIT : ST_IDLE;
                else if (start)
                    state_next = ST_QUERY_READ;
            end
            ST_FILL_UNIT:
                if (32'(k_reg) + 1 >= 32'(ndig_reg))
                    state_next = ST_FILL_SCAN;
            ST_FILL_SCAN:
                if (13'(cand_reg) + 13'd1 >= size.rows)
                    state_next = ST_IDLE;
                else
                    state_next = ST_FILL_SPLIT;
            ST_FILL_SPLIT:
                if (k_reg == CntW'(1))
                    state_next = ST_FILL_SCAN;
            ST_QUERY_READ:
                state_next = oor_reg ? ST_QUERY_DONE : ST_QUERY_SPLIT;
            ST_QUERY_SPLIT:
                if (k_reg == CntW'(1))
                    state_next = ST_QUERY_DONE;
            ST_QUERY_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Table port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = fill_reg;
        ram_wdata = '0;
        unique case (state_reg)
            ST_FILL_UNIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = VecW'(1) << (DigitW * k_reg);
            end
            ST_FILL_SCAN:
            begin
                ram_we    = (cand_reg != '0) && (lead_reg == 3'd1) && (nz_reg >= 4'd2);
                ram_wdata = vec_reg;
            end
            ST_IDLE:
                ram_addr = column_index;
            default:
                ram_addr = col_reg;
        endcase
    end

    assign busy = (state_reg != ST_IDLE) || refill_reg;

    // Hold configuration; a write to the base or digit-count register triggers a refill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 2'd0;
            ndig_reg   <= 4'd5;
            refill_reg <= 1'b1;
        end
        else if (wr_en && wr_index == RegBaseSelect)
        begin
            base_reg   <= wr_data[1:0];
            refill_reg <= 1'b1;
        end
        else if (wr_en && wr_index == RegDigitCount)
        begin
            ndig_reg   <= wr_data;
            refill_reg <= 1'b1;
        end
        else if (state_reg == ST_IDLE)
            refill_reg <= 1'b0;
    end

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_QUERY_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                k_reg    <= '0;
                fill_reg <= '0;
                cand_reg <= '0;
                nz_reg   <= '0;
                lead_reg <= '0;
                vec_reg  <= '0;
                sum_reg  <= '0;
                col_reg  <= column_index;
                val_reg  <= row_index;
                oor_reg  <= (13'(row_index) >= size.rows) || (column_index >= size.cols);
                oor_out_reg <= 1'b1;
                level_reg <= '0;
            end
            ST_FILL_UNIT:
            begin
                fill_reg <= fill_reg + AddrW'(1);
                k_reg    <= k_reg + CntW'(1);
            end
            ST_FILL_SCAN:
            begin
                if (ram_we)
                    fill_reg <= fill_reg + AddrW'(1);
                cand_reg <= cand_reg + RowW'(1);
                val_reg  <= cand_reg + RowW'(1);
                k_reg    <= CntW'(ndig_reg);
                nz_reg   <= '0;
                lead_reg <= '0;
                vec_reg  <= '0;
            end
            ST_FILL_SPLIT:
            begin
                // Digits come least significant first, i.e. from index n-1 down
                val_reg <= val_next;
                k_reg   <= k_reg - CntW'(1);
                vec_reg[DigitW*(k_reg - CntW'(1)) +: DigitW] <= digit;
                if (digit != 3'd0)
                begin
                    nz_reg   <= nz_reg + 4'd1;
                    lead_reg <= digit;
                end
            end
            ST_QUERY_READ:
                k_reg <= CntW'(ndig_reg);
            ST_QUERY_SPLIT:
            begin
                val_reg <= val_next;
                k_reg   <= k_reg - CntW'(1);
                sum_reg <= sum_next;
            end
            ST_QUERY_DONE:
            begin
                level_reg   <= sum_reg;
                oor_out_reg <= oor_reg;
            end
            default: ;
        endcase
    end

    assign done         = done_reg;
    assign level        = level_reg;
    assign out_of_range = oor_out_reg;
    assign row_count    = size.rows;
    assign column_count = size.cols;

endmodule

// ===== rtl/gfoa_size.sv =====
// Size decoder: row and column counts for the configured prime and digit count.
module gfoa_size (
    input  logic [1:0]               base_select,
    input  logic [3:0]               digit_count,
    output gfoa_pkg::size_t_t        size
);
    import gfoa_pkg::*;

    logic [2:0]  p;
    logic [15:0] rows_w;
    logic [15:0] cols_w;
    logic        n_ok;

    // Tabulate p^n and (p^n-1)/(p-1) for the small set of legal sizes
    always_comb
    begin
        p      = prime_of(base_select);
        rows_w = 16'd0;
        cols_w = 16'd0;
        n_ok   = (digit_count >= 4'd1) && (32'(digit_count) <= MaxDigits);
        case (p)
            3'd2:
            begin
                rows_w = 16'd1 << digit_count;
                cols_w = rows_w - 16'd1;
            end
            3'd3:
            begin
                case (digit_count)
                    4'd1:    rows_w = 16'd3;
                    4'd2:    rows_w = 16'd9;
                    4'd3:    rows_w = 16'd27;
                    4'd4:    rows_w = 16'd81;
                    4'd5:    rows_w = 16'd243;
                    4'd6:    rows_w = 16'd729;
                    4'd7:    rows_w = 16'd2187;
                    default: rows_w = 16'hFFFF;
                endcase
                cols_w = (rows_w - 16'd1) >> 1;
            end
            3'd5:
            begin
                case (digit_count)
                    4'd1:    rows_w = 16'd5;
                    4'd2:    rows_w = 16'd25;
                    4'd3:    rows_w = 16'd125;
                    4'd4:    rows_w = 16'd625;
                    4'd5:    rows_w = 16'd3125;
                    default: rows_w = 16'hFFFF;
                endcase
                cols_w = (rows_w - 16'd1) >> 2;
            end
            default:
            begin
                rows_w = 16'hFFFF;
                cols_w = 16'hFFFF;
            end
        endcase
        size.ok    = n_ok && (p != 3'd0) && (32'(rows_w) <= MaxRows)
                     && (32'(cols_w) <= TableDepth);
        size.prime = p;
        size.rows  = size.ok ? rows_w[RowCntW-1:0] : '0;
        size.cols  = size.ok ? cols_w[ColW-1:0] : '0;
    end

endmodule

// ===== rtl/gfoa_ram.sv =====
// Generic single-port RAM with registered read.
module gfoa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write or read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/gfoa_checker.sv =====
// Port-level checks for the orthogonal array generator, bound to the top level.
module gfoa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  level,
    input logic [12:0] row_count,
    input logic        out_of_range
);
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_level_zero_oor: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> level == 3'd0) else $error("level set on error");
    a_size_bad: assert property (@(posedge clk) disable iff (!rst_n)
        done && row_count == 13'd0 |-> out_of_range) else $error("bad size unflagged");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && row_count != 13'd0 |=> busy) else $error("no busy after accept");
endmodule

bind gf_prime_orthogonal_array_generator_top gfoa_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .level(level), .row_count(row_count), .out_of_range(out_of_range)
);
